@@ hdl/jsu_pkg.sv @@
// jsu_pkg: beat types, parser phase and status codes and character helpers
// for the json string unescaper; no dependencies
`timescale 1ns / 1ps

package jsu_pkg;

   localparam int CHAR_BITS = 16;

   // code units are cut to CHAR_BITS and then to the 16-bit field
   localparam logic [15:0] CHAR_MASK =
      (CHAR_BITS >= 16) ? 16'hFFFF : 16'((33'd1 << CHAR_BITS) - 33'd1);

   localparam logic [15:0] CH_QUOTE     = 16'h0022;
   localparam logic [15:0] CH_BACKSLASH = 16'h005C;
   localparam logic [15:0] CH_U         = 16'h0075;
   localparam logic [15:0] CH_B         = 16'h0062;
   localparam logic [15:0] CH_F         = 16'h0066;
   localparam logic [15:0] CH_N         = 16'h006E;
   localparam logic [15:0] CH_R         = 16'h0072;
   localparam logic [15:0] CH_T         = 16'h0074;
   localparam logic [15:0] CH_SPACE     = 16'h0020;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LEAD = 3'd1,
      PH_BODY = 3'd2,
      PH_ESC  = 3'd3,
      PH_HEX  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_BUSY = 2'd0,
      ST_DONE = 2'd1,
      ST_ERR  = 2'd2,
      ST_IDLE = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] ch;
      logic        start_req;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [15:0] out_ch;
      logic        out_valid;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  hex_count;
      logic [15:0] hex_value;
   } parse_state_type;

   function automatic logic is_blank(input logic [15:0] c);
      logic res;
      res = (c == CH_SPACE) || (c inside {[16'h0009:16'h000D]});
      return res;
   endfunction

   // bit 4 flags a valid hex digit, bits 3:0 carry its value
   function automatic logic [4:0] hex_digit(input logic [15:0] c);
      logic [4:0] res;
      res = 5'd0;
      if (c inside {[16'h0030:16'h0039]}) begin
         res = {1'b1, 4'(c - 16'h0030)};
      end else if (c inside {[16'h0061:16'h0066]}) begin
         res = {1'b1, 4'(c - 16'h0061 + 16'd10)};
      end else if (c inside {[16'h0041:16'h0046]}) begin
         res = {1'b1, 4'(c - 16'h0041 + 16'd10)};
      end
      return res;
   endfunction

   function automatic logic [15:0] escape_map(input logic [15:0] c);
      logic [15:0] res;
      case (c)
         CH_B: begin
            res = 16'h0008;
         end
         CH_F: begin
            res = 16'h000C;
         end
         CH_N: begin
            res = 16'h000A;
         end
         CH_R: begin
            res = 16'h000D;
         end
         CH_T: begin
            res = 16'h0009;
         end
         default: begin
            res = c;
         end
      endcase
      return res;
   endfunction

endpackage

@@ hdl/json_string_unescaper.sv @@
// json_string_unescaper: top level, input register, parser state and
// result register around jsu_decode; depends on jsu_pkg and jsu_decode
//
//   channel | ports                          | beat
//   --------+--------------------------------+---------------------------
//   input   | req_valid req_ready req_item   | one character, start, last
//   result  | rsp_valid rsp_ready rsp_item   | decoded char, valid, status
//
// every input beat gives exactly one result beat, passing through the input register and then the result register
// one beat per cycle sustained while rsp_ready stays high; the parser state is updated as a beat moves
// from the input register into the result register
// synchronous reset puts the parser in idle and empties both registers
// a stalled result holds the result register and, once the input register
// is full too, drops req_ready
`timescale 1ns / 1ps

module json_string_unescaper
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   logic            in_valid_ff;
   req_type         in_item_ff;
   logic            out_valid_ff;
   rsp_type         out_item_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   rsp_type         result_in;
   logic            advance;

   jsu_decode u_decode (
      .cur_state (state_ff),
      .item      (in_item_ff),
      .nxt_state (state_in),
      .result    (result_in)
   );

   // the input beat moves on when the result register is empty or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         state_ff.phase     <= PH_IDLE;
         state_ff.hex_count <= 2'd0;
         state_ff.hex_value <= 16'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= result_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

`ifndef SYNTHESIS
   // an error beat never carries a character
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_ERR) |->
         (!rsp_item.out_valid && rsp_item.out_ch == 16'd0))
      else $error("error beat carries a character");

   // an ignored character never produces output
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_IDLE) |-> !rsp_item.out_valid)
      else $error("idle beat carries a character");

   // a finished or failed string leaves the parser idle
   assert property (@(posedge clock) disable iff (reset)
      (advance && (result_in.status == ST_DONE || result_in.status == ST_ERR)) |=>
         (state_ff.phase == PH_IDLE && state_ff.hex_count == 2'd0))
      else $error("parser not idle after string end");

   // hex digits are only counted while gathering a unicode escape
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.hex_count != 2'd0) |-> (state_ff.phase == PH_HEX))
      else $error("hex count outside unicode escape");
`endif

endmodule

@@ hdl/jsu_decode.sv @@
// jsu_decode: one-character step of the string parser, giving the next
// parser state and the result beat; depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_decode
   import jsu_pkg::*;
(
   input  parse_state_type cur_state,
   input  req_type         item,
   output parse_state_type nxt_state,
   output rsp_type         result
);

   logic [15:0]     c;
   logic [4:0]      dig;
   logic [15:0]     hex_new;
   logic [15:0]     och;
   logic            vld;
   status_type      st;
   parse_state_type base;
   parse_state_type nxt;

   always_comb begin
      c   = item.ch & CHAR_MASK;
      dig = hex_digit(c);
      och = 16'd0;
      vld = 1'b0;
      st  = ST_BUSY;

      base = cur_state;
      if (item.start_req) begin
         base.phase     = PH_LEAD;
         base.hex_count = 2'd0;
         base.hex_value = 16'd0;
      end
      nxt     = base;
      hex_new = {base.hex_value[11:0], dig[3:0]};

      case (base.phase)
         PH_LEAD: begin
            if (c == CH_QUOTE) begin
               nxt.phase = PH_BODY;
            end else if (!is_blank(c)) begin
               st = ST_ERR;
            end
         end
         PH_BODY: begin
            if (c == CH_QUOTE) begin
               st = ST_DONE;
            end else if (c == CH_BACKSLASH) begin
               nxt.phase = PH_ESC;
            end else begin
               och = c;
               vld = 1'b1;
            end
         end
         PH_ESC: begin
            if (c == CH_U) begin
               nxt.phase     = PH_HEX;
               nxt.hex_count = 2'd0;
               nxt.hex_value = 16'd0;
            end else begin
               och       = escape_map(c);
               vld       = 1'b1;
               nxt.phase = PH_BODY;
            end
         end
         PH_HEX: begin
            if (!dig[4]) begin
               st = ST_ERR;
            end else begin
               nxt.hex_value = hex_new;
               if (base.hex_count == 2'd3) begin
                  och           = hex_new & CHAR_MASK;
                  vld           = 1'b1;
                  nxt.hex_count = 2'd0;
                  nxt.phase     = PH_BODY;
               end else begin
                  nxt.hex_count = base.hex_count + 2'd1;
               end
            end
         end
         default: begin
            // idle: character ignored until the next start request
            st        = ST_IDLE;
            nxt.phase = PH_IDLE;
         end
      endcase

      if (st == ST_BUSY && item.last) begin
         st = ST_ERR;
      end
      if (st == ST_ERR || st == ST_DONE) begin
         nxt.phase     = PH_IDLE;
         nxt.hex_count = 2'd0;
         nxt.hex_value = 16'd0;
      end
      if (st == ST_ERR) begin
         och = 16'd0;
         vld = 1'b0;
      end

      nxt_state        = nxt;
      result.out_ch    = och;
      result.out_valid = vld;
      result.status    = st;
   end

endmodule
